// File: rtl/core/ddm_pkg.sv
// Shared constants, codes and types of the differential-drive duty mixer.
// No dependencies; imported by the mixer, its divider and its checker.
package ddm_pkg;

  // Velocity and half-track fraction bits
  localparam int VEL_FRAC_BITS = 12;

  // Field and register widths
  localparam int GAIN_W    = 10;
  localparam int GAIN_FRAC = 8;
  localparam int MS_W      = 15;
  localparam int HT_W      = 13;
  localparam int DB_W      = 12;
  localparam int TO_W      = 8;
  localparam int CMD_W     = 16;
  localparam int DUTY_W    = 8;
  localparam int DIR_W     = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 15;

  // Datapath widths
  localparam int ANG_W       = CMD_W + GAIN_W - GAIN_FRAC;   // scaled speed magnitude
  localparam int PROD_W      = ANG_W + HT_W;                 // shared multiplier output
  localparam int NUM_W       = MS_W + VEL_FRAC_BITS;         // yaw limit dividend
  localparam int QUO_W       = ANG_W;                        // divider quotient register
  localparam int WHL_W       = PROD_W - VEL_FRAC_BITS + 2;   // signed wheel speed
  localparam int DUTY_Q_W    = 7;                            // duty quotient bits
  localparam int DUTY_PROD_W = MS_W + DUTY_Q_W;
  localparam int STEP_W      = $clog2(QUO_W + 1);

  localparam int DUTY_SCALE = 100;
  localparam int DUTY_CAP   = 99;

  // Opcodes
  localparam logic OP_CMD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_TR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 3'd4;

  // Sign-pattern codes
  typedef enum logic [DIR_W-1:0] {
    DIR_STOP  = 3'd0,
    DIR_FWD   = 3'd1,
    DIR_REV   = 3'd2,
    DIR_RBACK = 3'd3,
    DIR_LBACK = 3'd4
  } dir_t;

  // Request to the iterative divider
  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [MS_W-1:0]   rem;
    logic [QUO_W-1:0]  dq;
    logic [MS_W-1:0]   divisor;
  } div_req_t;

endpackage

// File: rtl/core/ddm_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on ddm_pkg (widths, div_req_t).
module ddm_div import ddm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  output logic             done,
  output logic [QUO_W-1:0] quo
);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [MS_W-1:0]   rem_r;
  logic [MS_W-1:0]   div_r;
  logic [QUO_W-1:0]  dq_r;

  logic [MS_W:0]     trial;
  logic [MS_W:0]     diff;
  logic              ge;
  logic [MS_W-1:0]   rem_nxt;
  logic [QUO_W-1:0]  dq_nxt;

  // remainder stays below the divisor, so one shift-subtract per bit
  always_comb begin
    trial   = {rem_r, dq_r[QUO_W-1]};
    diff    = trial - {1'b0, div_r};
    ge      = (trial >= {1'b0, div_r});
    rem_nxt = ge ? diff[MS_W-1:0] : trial[MS_W-1:0];
    dq_nxt  = {dq_r[QUO_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.rem;
      dq_r  <= req.dq;
      div_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dq_r  <= dq_nxt;
    end
  end

  assign done = done_r;
  assign quo  = dq_r;

endmodule

// File: rtl/core/diff_drive_duty_mixer.sv
// Differential-drive duty mixer: top level with sequencer and shared datapath.
// Depends on ddm_pkg and ddm_div.
//
// A velocity command (in_opcode 0) is scaled by cmd_gain, limited so neither
// wheel exceeds max_speed, mixed into left/right wheel speeds and stored as
// duty percentages plus a sign-pattern code; it produces no output transaction.
// An output tick (in_opcode 1) ages the last command, stops the drive once the
// age passes timeout_ticks, and produces one output transaction with signed
// duties (zero while stopped) and the run flag. in_stall is high while an item
// is in work. All arithmetic runs through one shared multiplier and one
// bit-serial divider under a small state machine. A command runs S_LIN, S_ANG,
// S_CLAMP, S_CHK, S_CMP, S_SUM, both wheel duties and S_COMMIT; when the yaw
// rate has to be limited, S_DIV adds the 18-step yaw-limit division and a
// re-check through S_CHK and S_CMP. Each wheel's duty takes the product, the
// divider start and the 7-step division. A tick loads the output register and
// waits only while a previous result is still stalled in the output register.
// The output register decouples the sides, so a command is taken while a
// result waits.
module diff_drive_duty_mixer import ddm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_opcode,
  input  logic signed [CMD_W-1:0]  in_linear_cmd,
  input  logic signed [CMD_W-1:0]  in_angular_cmd,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DUTY_W-1:0] out_left_duty,
  output logic signed [DUTY_W-1:0] out_right_duty,
  output logic [DIR_W-1:0]         out_direction_code,
  output logic                     out_running,
  // configuration
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LIN,     // |linear| * gain
    S_ANG,     // |angular| * gain
    S_CLAMP,   // deadband test, linear clamp
    S_CHK,     // |angular| * half_track
    S_CMP,     // compare against yaw limit, start division if over
    S_DIV,     // yaw-limit division
    S_SUM,     // wheel speeds
    S_DMUL,    // |wheel| * 100
    S_DSTART,  // start duty division
    S_DWAIT,
    S_COMMIT,
    S_TICK
  } state_t;

  // configuration registers
  logic [GAIN_W-1:0] gain_r;
  logic [MS_W-1:0]   ms_r;
  logic [HT_W-1:0]   ht_r;
  logic [DB_W-1:0]   db_r;
  logic [TO_W-1:0]   to_r;

  // control state
  state_t                 state_r;
  logic                   run_r;
  logic                   run_pend_r;
  logic [TO_W-1:0]        age_r;
  logic [DUTY_Q_W-1:0]    rduty_r;
  logic [DUTY_Q_W-1:0]    lduty_r;
  dir_t                   dir_r;
  logic                   side_r;      // 0 right wheel, 1 left wheel
  logic                   out_valid_r;

  // working registers
  logic [CMD_W-1:0]         lin_cmd_r;
  logic [CMD_W-1:0]         ang_cmd_r;
  logic [ANG_W-1:0]         lin_mag_r;
  logic [ANG_W-1:0]         ang_mag_r;
  logic                     lin_neg_r;
  logic                     ang_neg_r;
  logic [PROD_W-1:0]        prod_r;
  logic signed [WHL_W-1:0]  r_r;
  logic signed [WHL_W-1:0]  l_r;

  // output payload registers
  logic signed [DUTY_W-1:0] out_left_r;
  logic signed [DUTY_W-1:0] out_right_r;
  logic [DIR_W-1:0]         out_dir_r;
  logic                     out_run_r;

  // combinational
  logic [MS_W-1:0]          ms_eff;
  logic [HT_W-1:0]          ht_eff;
  logic [CMD_W-1:0]         lin_abs;
  logic [CMD_W-1:0]         ang_abs;
  logic [ANG_W-1:0]         scaled_mag;
  logic [MS_W-1:0]          span;
  logic [NUM_W-1:0]         lim_num;
  logic                     over_lim;
  logic signed [WHL_W-1:0]  lin_s;
  logic signed [WHL_W-1:0]  term_s;
  logic [WHL_W-1:0]         term_mag;
  logic signed [WHL_W-1:0]  wheel;
  logic [WHL_W-1:0]         wheel_mag;
  logic                     wheel_big;
  logic [ANG_W-1:0]         mul_a;
  logic [HT_W-1:0]          mul_b;
  logic [PROD_W-1:0]        mul_p;
  div_req_t                 div_req;
  logic                     div_done;
  logic [QUO_W-1:0]         div_quo;
  logic [WHL_W-1:0]         r_mag;
  logic [WHL_W-1:0]         l_mag;
  dir_t                     dir_calc;
  logic [TO_W-1:0]          age_inc;
  logic                     run_tick;
  logic [DUTY_W-1:0]        lm8;
  logic [DUTY_W-1:0]        rm8;
  logic signed [DUTY_W-1:0] tick_l;
  logic signed [DUTY_W-1:0] tick_r;
  logic                     out_free;

  // zero divisors behave as one
  assign ms_eff = (ms_r == '0) ? MS_W'(1) : ms_r;
  assign ht_eff = (ht_r == '0) ? HT_W'(1) : ht_r;

  assign lin_abs    = lin_cmd_r[CMD_W-1] ? (~lin_cmd_r + 1'b1) : lin_cmd_r;
  assign ang_abs    = ang_cmd_r[CMD_W-1] ? (~ang_cmd_r + 1'b1) : ang_cmd_r;
  assign scaled_mag = prod_r[GAIN_FRAC +: ANG_W];

  // yaw limit numerator; lin_mag_r is already clamped to max_speed here
  assign span     = ms_eff - lin_mag_r[MS_W-1:0];
  assign lim_num  = {span, {VEL_FRAC_BITS{1'b0}}};
  // |ang| > floor(N/ht) exactly when |ang|*ht > N
  assign over_lim = (prod_r > PROD_W'(lim_num));

  assign term_mag = WHL_W'(prod_r >> VEL_FRAC_BITS);
  assign lin_s    = lin_neg_r ? -$signed(WHL_W'(lin_mag_r)) : $signed(WHL_W'(lin_mag_r));
  assign term_s   = ang_neg_r ? -$signed(term_mag) : $signed(term_mag);

  assign wheel     = side_r ? l_r : r_r;
  assign wheel_mag = wheel[WHL_W-1] ? WHL_W'(-wheel) : WHL_W'(wheel);
  assign wheel_big = (wheel_mag > WHL_W'(ms_eff));

  // shared multiplier
  always_comb begin
    case (state_r)
      S_LIN: begin
        mul_a = ANG_W'(lin_abs);
        mul_b = HT_W'(gain_r);
      end
      S_ANG: begin
        mul_a = ANG_W'(ang_abs);
        mul_b = HT_W'(gain_r);
      end
      S_CHK: begin
        mul_a = ang_mag_r;
        mul_b = ht_eff;
      end
      default: begin
        mul_a = ANG_W'(wheel_mag[MS_W-1:0]);
        mul_b = HT_W'(DUTY_SCALE);
      end
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // divider requests: yaw limit (18 quotient bits) or duty (7 bits)
  always_comb begin
    div_req = '0;
    if (state_r == S_CMP && over_lim) begin
      div_req.start   = 1'b1;
      div_req.steps   = STEP_W'(QUO_W);
      div_req.rem     = MS_W'(lim_num[NUM_W-1:QUO_W]);
      div_req.dq      = lim_num[QUO_W-1:0];
      div_req.divisor = MS_W'(ht_eff);
    end else if (state_r == S_DSTART) begin
      div_req.start   = 1'b1;
      div_req.steps   = STEP_W'(DUTY_Q_W);
      div_req.rem     = prod_r[DUTY_PROD_W-1:DUTY_Q_W];
      div_req.dq      = {prod_r[DUTY_Q_W-1:0], {(QUO_W - DUTY_Q_W){1'b0}}};
      div_req.divisor = ms_eff;
    end
  end

  ddm_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .done (div_done),
    .quo  (div_quo)
  );

  // sign-pattern code from the finished wheel speeds
  assign r_mag = r_r[WHL_W-1] ? WHL_W'(-r_r) : WHL_W'(r_r);
  assign l_mag = l_r[WHL_W-1] ? WHL_W'(-l_r) : WHL_W'(l_r);

  always_comb begin
    if (r_mag < WHL_W'(db_r) && l_mag < WHL_W'(db_r))  dir_calc = DIR_STOP;
    else if (r_r > 0 && l_r > 0)                       dir_calc = DIR_FWD;
    else if (r_r < 0 && l_r < 0)                       dir_calc = DIR_REV;
    else if (r_r < 0 && l_r > 0)                       dir_calc = DIR_RBACK;
    else if (r_r > 0 && l_r < 0)                       dir_calc = DIR_LBACK;
    else                                               dir_calc = DIR_STOP;
  end

  // tick: saturating age, timeout, signed duties
  assign age_inc  = (age_r == '1) ? age_r : age_r + 1'b1;
  assign run_tick = run_r && !(age_inc > to_r);
  assign lm8      = DUTY_W'(lduty_r);
  assign rm8      = DUTY_W'(rduty_r);

  always_comb begin
    tick_l = '0;
    tick_r = '0;
    if (run_tick) begin
      case (dir_r)
        DIR_FWD: begin
          tick_l = $signed(lm8);
          tick_r = $signed(rm8);
        end
        DIR_REV: begin
          tick_l = -$signed(lm8);
          tick_r = -$signed(rm8);
        end
        DIR_RBACK: begin
          tick_l = $signed(lm8);
          tick_r = -$signed(rm8);
        end
        DIR_LBACK: begin
          tick_l = -$signed(lm8);
          tick_r = $signed(rm8);
        end
        default: begin
          tick_l = '0;
          tick_r = '0;
        end
      endcase
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  // sequencer, control state, configuration and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      run_r       <= 1'b0;
      run_pend_r  <= 1'b0;
      age_r       <= '0;
      rduty_r     <= '0;
      lduty_r     <= '0;
      dir_r       <= DIR_STOP;
      side_r      <= 1'b0;
      out_valid_r <= 1'b0;
      gain_r      <= GAIN_W'(307);
      ms_r        <= MS_W'(6434);
      ht_r        <= HT_W'(2058);
      db_r        <= DB_W'(4);
      to_r        <= TO_W'(12);
    end else begin
      // result held while stalled, loaded by a tick once the register is free
      out_valid_r <= (out_valid_r && out_stall) || (state_r == S_TICK && out_free);

      if (cfg_we) begin
        case (cfg_index)
          CFG_GAIN:    gain_r <= cfg_wdata[GAIN_W-1:0];
          CFG_MAX_SPD: ms_r   <= cfg_wdata[MS_W-1:0];
          CFG_HALF_TR: ht_r   <= cfg_wdata[HT_W-1:0];
          CFG_DEADBND: db_r   <= cfg_wdata[DB_W-1:0];
          CFG_TIMEOUT: to_r   <= cfg_wdata[TO_W-1:0];
          default: ;
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) state_r <= (in_opcode == OP_TICK) ? S_TICK : S_LIN;
        end
        S_LIN:   state_r <= S_ANG;
        S_ANG:   state_r <= S_CLAMP;
        S_CLAMP: begin
          // both scaled speeds inside the deadband: the drive is stopped
          run_pend_r <= !(lin_mag_r < ANG_W'(db_r) && scaled_mag < ANG_W'(db_r));
          state_r    <= S_CHK;
        end
        S_CHK:   state_r <= S_CMP;
        S_CMP:   state_r <= over_lim ? S_DIV : S_SUM;
        S_DIV: begin
          if (div_done) state_r <= S_CHK;   // re-run the product with the limit
        end
        S_SUM: begin
          side_r  <= 1'b0;
          state_r <= S_DMUL;
        end
        S_DMUL: begin
          if (wheel_big) begin
            if (side_r) begin
              lduty_r <= DUTY_Q_W'(DUTY_CAP);
              state_r <= S_COMMIT;
            end else begin
              rduty_r <= DUTY_Q_W'(DUTY_CAP);
              side_r  <= 1'b1;
            end
          end else begin
            state_r <= S_DSTART;
          end
        end
        S_DSTART: state_r <= S_DWAIT;
        S_DWAIT: begin
          if (div_done) begin
            if (side_r) begin
              lduty_r <= div_quo[DUTY_Q_W-1:0];
              state_r <= S_COMMIT;
            end else begin
              rduty_r <= div_quo[DUTY_Q_W-1:0];
              side_r  <= 1'b1;
              state_r <= S_DMUL;
            end
          end
        end
        S_COMMIT: begin
          dir_r   <= dir_calc;
          run_r   <= run_pend_r;
          age_r   <= '0;
          state_r <= S_IDLE;
        end
        S_TICK: begin
          if (out_free) begin
            age_r   <= age_inc;
            run_r   <= run_tick;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      lin_cmd_r <= in_linear_cmd;
      ang_cmd_r <= in_angular_cmd;
    end
    case (state_r)
      S_LIN: begin
        lin_neg_r <= lin_cmd_r[CMD_W-1];
        prod_r    <= mul_p;
      end
      S_ANG: begin
        lin_mag_r <= scaled_mag;
        ang_neg_r <= !ang_cmd_r[CMD_W-1];   // yaw rate is negated
        prod_r    <= mul_p;
      end
      S_CLAMP: begin
        ang_mag_r <= scaled_mag;
        if (lin_mag_r > ANG_W'(ms_eff)) lin_mag_r <= ANG_W'(ms_eff);
      end
      S_CHK: prod_r <= mul_p;
      S_DIV: begin
        if (div_done) ang_mag_r <= div_quo;
      end
      S_SUM: begin
        r_r <= lin_s + term_s;
        l_r <= lin_s - term_s;
      end
      S_DMUL: prod_r <= mul_p;
      S_TICK: begin
        if (out_free) begin
          out_left_r  <= tick_l;
          out_right_r <= tick_r;
          out_dir_r   <= run_tick ? dir_r : DIR_STOP;
          out_run_r   <= run_tick;
        end
      end
      default: ;
    endcase
  end

  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_left_duty      = out_left_r;
  assign out_right_duty     = out_right_r;
  assign out_direction_code = out_dir_r;
  assign out_running        = out_run_r;

endmodule

// File: rtl/core/ddm_checker.sv
// Port-level checker for the duty mixer, bound to the top level.
// Depends on ddm_pkg (codes, widths) and diff_drive_duty_mixer.
module ddm_checker import ddm_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [DUTY_W-1:0] out_left_duty,
  input logic signed [DUTY_W-1:0] out_right_duty,
  input logic [DIR_W-1:0]         out_direction_code,
  input logic                     out_running
);

  // stopped drive reports zero duties and the stop code
  a_stopped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_running |->
      out_left_duty == '0 && out_right_duty == '0 && out_direction_code == DIR_STOP)
    else $error("stopped result carries nonzero duty or code");

  // stop code always means zero duties
  a_code_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_direction_code == DIR_STOP |->
      out_left_duty == '0 && out_right_duty == '0)
    else $error("stop code with nonzero duty");

  // forward code means both duties non-negative
  a_fwd_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_direction_code == DIR_FWD |->
      !out_left_duty[DUTY_W-1] && !out_right_duty[DUTY_W-1])
    else $error("forward code with a reverse duty");

  // every accepted transaction raises in_stall in the following cycle
  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("transaction accepted back to back");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable(out_left_duty) && $stable(out_right_duty))
    else $error("stalled result changed");

endmodule

bind diff_drive_duty_mixer ddm_checker u_ddm_checker (.*);

// File: sim/tb_diff_drive_duty_mixer.sv
`timescale 1ns / 100ps
// Self-checking testbench of diff_drive_duty_mixer: directed and random transactions,
// each tick's result checked against a behavioral predictor. Needs ddm_pkg and the RTL.
module tb_diff_drive_duty_mixer;
  import ddm_pkg::*;

  // A command yields no result to wait for, so give the block well over a
  // command's run before touching registers or ending the run.
  localparam int     SETTLE_CYCLES = 64;
  localparam longint CYCLE_LIMIT   = 1_000_000;

  typedef struct {
    logic signed [DUTY_W-1:0] left;
    logic signed [DUTY_W-1:0] right;
    dir_t                     dir;
    logic                     running;
  } duty_result_t;

  // DUT ports, inputs all known from time zero
  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     in_opcode = OP_CMD;
  logic signed [CMD_W-1:0]  in_linear_cmd = '0;
  logic signed [CMD_W-1:0]  in_angular_cmd = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DUTY_W-1:0] out_left_duty;
  logic signed [DUTY_W-1:0] out_right_duty;
  logic [DIR_W-1:0]         out_direction_code;
  logic                     out_running;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = CFG_GAIN;
  logic [CFG_W-1:0]         cfg_wdata = '0;

  // Predictor copy of the registers (reset values) and of the drive state
  logic [GAIN_W-1:0] gain_q     = 10'd307;
  logic [MS_W-1:0]   max_spd_q  = 15'd6434;
  logic [HT_W-1:0]   half_tr_q  = 13'd2058;
  logic [DB_W-1:0]   deadband_q = 12'd4;
  logic [TO_W-1:0]   timeout_q  = 8'd12;

  logic              drive_on  = 1'b0;
  logic [7:0]        cmd_age   = '0;
  logic [DUTY_W-1:0] left_mag  = '0;
  logic [DUTY_W-1:0] right_mag = '0;
  dir_t              dir_held  = DIR_STOP;

  duty_result_t pending_duties[$];   // results owed by accepted ticks, oldest first
  int           items_sent  = 0;
  int           err_count   = 0;
  bit           quiet       = 1'b0;  // no gaps and no stalls while set
  int           stall_run   = 0;
  longint       cycle_count = 0;

  diff_drive_duty_mixer uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_linear_cmd      (in_linear_cmd),
    .in_angular_cmd     (in_angular_cmd),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_left_duty      (out_left_duty),
    .out_right_duty     (out_right_duty),
    .out_direction_code (out_direction_code),
    .out_running        (out_running),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic longint mag_of(longint a);
    return (a < 0) ? -a : a;
  endfunction

  // exact product, shifted, truncated toward zero; sign of a restored
  function automatic longint scale_trunc(longint a, longint b, int sh);
    longint m;
    m = (mag_of(a) * b) >> sh;
    return (a < 0) ? -m : m;
  endfunction

  // wheel speed to duty percent; anything above max speed reads as the cap
  function automatic logic [DUTY_W-1:0] duty_percent(longint w, longint ms);
    if (mag_of(w) > ms) return DUTY_W'(DUTY_CAP);
    return DUTY_W'(mag_of(w) * DUTY_SCALE / ms);
  endfunction

  // Velocity command: scale, limit, mix into wheel speeds, store duties and code.
  function automatic void mix_command(logic signed [CMD_W-1:0] lc,
                                      logic signed [CMD_W-1:0] ac);
    longint ms, ht, db, lin, ang, lim, term, r, l;
    ms  = (max_spd_q == 0) ? 1 : longint'(max_spd_q);   // zero divisors act as 1
    ht  = (half_tr_q == 0) ? 1 : longint'(half_tr_q);
    db  = longint'(deadband_q);
    lin = scale_trunc(longint'(lc), longint'(gain_q), GAIN_FRAC);
    ang = -scale_trunc(longint'(ac), longint'(gain_q), GAIN_FRAC);

    cmd_age  = '0;
    // deadband applies to the scaled speeds before any limiting
    drive_on = !(mag_of(lin) < db && mag_of(ang) < db);

    if (lin > ms) lin = ms;
    else if (lin < -ms) lin = -ms;
    // yaw limit leaves headroom so neither wheel passes max speed
    lim = ((ms - mag_of(lin)) << VEL_FRAC_BITS) / ht;
    if (ang > lim) ang = lim;
    else if (ang < -lim) ang = -lim;

    term = scale_trunc(ang, ht, VEL_FRAC_BITS);
    r = lin + term;
    l = lin - term;
    right_mag = duty_percent(r, ms);
    left_mag  = duty_percent(l, ms);

    // code 0 when both wheels sit in the deadband or either is exactly zero
    if (mag_of(r) < db && mag_of(l) < db) dir_held = DIR_STOP;
    else if (r > 0 && l > 0) dir_held = DIR_FWD;
    else if (r < 0 && l < 0) dir_held = DIR_REV;
    else if (r < 0 && l > 0) dir_held = DIR_RBACK;
    else if (r > 0 && l < 0) dir_held = DIR_LBACK;
    else dir_held = DIR_STOP;
  endfunction

  // Output tick: age the command, time out, emit signed duties or zeros.
  function automatic duty_result_t age_and_emit();
    duty_result_t res;
    if (cmd_age != 8'd255) cmd_age = cmd_age + 8'd1;
    if (cmd_age > timeout_q) drive_on = 1'b0;
    res.left    = '0;
    res.right   = '0;
    res.dir     = DIR_STOP;
    res.running = drive_on;
    if (drive_on) begin
      res.dir = dir_held;
      case (dir_held)
        DIR_FWD: begin
          res.left  = left_mag;
          res.right = right_mag;
        end
        DIR_REV: begin
          res.left  = -left_mag;
          res.right = -right_mag;
        end
        DIR_RBACK: begin
          res.left  = left_mag;
          res.right = -right_mag;
        end
        DIR_LBACK: begin
          res.left  = -left_mag;
          res.right = right_mag;
        end
        default: ;
      endcase
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts, and the checker
  // ---------------------------------------------------------------------------
  // Mostly short stalls between runs of open cycles, now and then a long one.
  always @(posedge clk) begin
    int pick;
    if (quiet) begin
      out_stall <= 1'b0;
      stall_run = 0;
    end else if (stall_run > 0) begin
      stall_run--;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        out_stall <= 1'b0;
        stall_run = $urandom_range(0, 15);
      end else if (pick < 95) begin
        out_stall <= 1'b1;
        stall_run = $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b1;
        stall_run = $urandom_range(20, 50);
      end
    end
  end

  // Every accepted result transaction is matched against the oldest prediction.
  always @(posedge clk) begin
    duty_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_duties.size() == 0) begin
        $error("result with nothing pending: left %0d right %0d code %0d running %0d",
               out_left_duty, out_right_duty, out_direction_code, out_running);
        err_count++;
      end else begin
        want = pending_duties.pop_front();
        if (out_left_duty !== want.left) begin
          $error("left_duty: expected %0d, got %0d", want.left, out_left_duty);
          err_count++;
        end
        if (out_right_duty !== want.right) begin
          $error("right_duty: expected %0d, got %0d", want.right, out_right_duty);
          err_count++;
        end
        if (out_direction_code !== want.dir) begin
          $error("direction_code: expected %0d, got %0d", want.dir, out_direction_code);
          err_count++;
        end
        if (out_running !== want.running) begin
          $error("running: expected %0d, got %0d", want.running, out_running);
          err_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // Sender gap after a transaction: mostly none or short, a few long.
  task automatic idle_gap();
    int pick, n;
    if (quiet) return;
    pick = $urandom_range(0, 99);
    if (pick < 55) n = 0;
    else if (pick < 93) n = $urandom_range(1, 3);
    else n = $urandom_range(20, 50);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Present one item, hold it until accepted, then update the predictor.
  // Valid stays high when no gap follows, so the next item goes back to back.
  task automatic send_item(logic op, logic signed [CMD_W-1:0] lc,
                           logic signed [CMD_W-1:0] ac);
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_linear_cmd  <= lc;
    in_angular_cmd <= ac;
    do @(posedge clk); while (in_stall);
    if (op == OP_CMD) mix_command(lc, ac);
    else pending_duties.push_back(age_and_emit());
    items_sent++;
    idle_gap();
  endtask

  // Drop valid, wait for every owed result, then let a command still in work finish.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_duties.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(value);
    @(posedge clk);
    case (idx)
      CFG_GAIN:    gain_q     = GAIN_W'(value);
      CFG_MAX_SPD: max_spd_q  = MS_W'(value);
      CFG_HALF_TR: half_tr_q  = HT_W'(value);
      CFG_DEADBND: deadband_q = DB_W'(value);
      CFG_TIMEOUT: timeout_q  = TO_W'(value);
      default: ;
    endcase
  endtask

  // Registers change only with the block idle; write enable drops once at the end.
  task automatic load_setting(int unsigned gain, int unsigned max_spd, int unsigned half_tr,
                              int unsigned deadband, int unsigned timeout);
    settle();
    write_reg(CFG_GAIN, gain);
    write_reg(CFG_MAX_SPD, max_spd);
    write_reg(CFG_HALF_TR, half_tr);
    write_reg(CFG_DEADBND, deadband);
    write_reg(CFG_TIMEOUT, timeout);
    cfg_we <= 1'b0;
  endtask

  // Requested speed: full-range noise, values near the deadband after gain,
  // field extremes, and moderate values.
  function automatic logic signed [CMD_W-1:0] pick_velocity();
    int pick, hi;
    logic signed [CMD_W-1:0] v;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      v = CMD_W'($urandom);
    end else if (pick < 70) begin
      hi = (2 * int'(deadband_q) + 8) * (1 << GAIN_FRAC) / (int'(gain_q) + 1) + 1;
      if (hi > 32767) hi = 32767;
      v = CMD_W'($urandom_range(0, hi));
      if ($urandom_range(0, 1)) v = -v;
    end else if (pick < 80) begin
      case ($urandom_range(0, 2))
        0: v = 16'sh7FFF;
        1: v = 16'sh8000;
        default: v = '0;
      endcase
    end else begin
      v = CMD_W'($urandom_range(0, 8192));
      if ($urandom_range(0, 1)) v = -v;
    end
    return v;
  endfunction

  // Mostly a command followed by a run of ticks, sometimes long enough to
  // time out; the rest are back-to-back commands and random items.
  task automatic run_traffic(int n, bit calm);
    int stop_at, ticks, pick;
    quiet   = calm;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        send_item(OP_CMD, pick_velocity(), pick_velocity());
        if ($urandom_range(0, 9) == 0) ticks = int'(timeout_q) + $urandom_range(1, 3);
        else ticks = $urandom_range(1, 6);
        repeat (ticks) send_item(OP_TICK, CMD_W'($urandom), CMD_W'($urandom));
      end else if (pick < 90) begin
        send_item(OP_CMD, pick_velocity(), pick_velocity());
      end else begin
        send_item($urandom_range(0, 1) ? OP_TICK : OP_CMD,
                  CMD_W'($urandom), CMD_W'($urandom));
      end
    end
    quiet = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Ticks before any command: stopped, all zeros.
  task automatic test_startup_ticks();
    send_item(OP_TICK, '0, '0);
    send_item(OP_TICK, 16'sh7FFF, 16'sh8000);
  endtask

  // Field extremes and every sign pattern, each command read back by a tick.
  task automatic test_directed_extremes();
    logic signed [CMD_W-1:0] lin_set[9] = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0000,
                                           16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0002,
                                           16'sh0FA0};
    logic signed [CMD_W-1:0] ang_set[9] = '{16'sh0000, 16'sh0000, 16'sh7FFF, 16'sh8000,
                                           16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFE,
                                           16'shFA24};
    for (int k = 0; k < 9; k++) begin
      send_item(OP_CMD, lin_set[k], ang_set[k]);
      send_item(OP_TICK, ~lin_set[k], ~ang_set[k]);   // tick payload is ignored
    end
  endtask

  // Unity gain and half track make the yaw term equal the linear speed, so the
  // left wheel lands on exactly zero: running but code stop. With a timeout of
  // one the second tick already stops the drive.
  task automatic test_zero_wheel_and_timeout();
    load_setting(256, 6434, 4096, 4, 1);
    send_item(OP_CMD, 16'sd1000, -16'sd1000);
    repeat (3) send_item(OP_TICK, '0, '0);
  endtask

  // Register sweep across the extremes, including zero divisors, zero gain,
  // zero deadband and a zero timeout; some phases without gaps or stalls.
  task automatic test_setting_sweep();
    load_setting(1023, 32767, 8191, 4095, 255);
    run_traffic(150, 1'b0);
    load_setting(0, 1, 1, 0, 1);
    run_traffic(120, 1'b1);
    load_setting(1023, 1, 8191, 0, 0);
    run_traffic(150, 1'b0);
    load_setting(512, 32767, 1, 100, 3);
    run_traffic(150, 1'b0);
    load_setting(256, 0, 0, 4, 5);
    run_traffic(120, 1'b0);
    load_setting(128, 16384, 4096, 0, 255);
    run_traffic(150, 1'b1);
    repeat (2) begin
      load_setting($urandom_range(0, 1023), $urandom_range(1, 32767),
                   $urandom_range(1, 8191), $urandom_range(0, 300), $urandom_range(1, 20));
      run_traffic(150, 1'b0);
    end
  endtask

  // Back at the reset values; the sender drains everything once mid-run.
  task automatic test_random_traffic();
    load_setting(307, 6434, 2058, 4, 12);
    run_traffic(250, 1'b0);
    settle();
    run_traffic(250, 1'b0);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_startup_ticks();
    test_directed_extremes();
    test_zero_wheel_and_timeout();
    test_setting_sweep();
    test_random_traffic();

    settle();
    if (err_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/ddm_pkg.sv
rtl/core/ddm_div.sv
rtl/core/diff_drive_duty_mixer.sv
rtl/core/ddm_checker.sv
sim/tb_diff_drive_duty_mixer.sv
